>>> rtl/core/bprt_pkg.sv
// Package for the broadcast page reassembly tracker.
// Holds table sizes, status codes, controller states and the command/status structs.
// No dependencies.
package bprt_pkg;

	localparam int Entries = 8;
	localparam int PageLimit = 15;
	localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int KeyW = 28;

	typedef enum logic [2:0] {
		ST_RECORDED  = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_STALE     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic dummy_ok;
	} dp_stat_t;

endpackage

>>> rtl/core/bprt_ctrl.sv
// Controller for the page tracker: sequences capture, table update and result beat.
// Depends on bprt_pkg.
module bprt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bprt_pkg::dp_stat_t stat,
	output bprt_pkg::dp_cmd_t  cmd
);
	import bprt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_LOOKUP;
			S_LOOKUP: state_d = S_HOLD;
			S_HOLD: begin
				if (!out_stall) state_d = in_valid ? S_LOOKUP : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// A new beat is taken in idle, or in the hold state as the held result leaves.
	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			S_LOOKUP: begin
				cmd.update = stat.dummy_ok;
				cmd.load_out = 1'b1;
			end
			S_HOLD: begin
				out_valid = 1'b1;
				in_stall = out_stall;
				cmd.capture = in_valid && !out_stall;
			end
			default: ;
		endcase
	end
endmodule

>>> rtl/core/bprt_dp.sv
// Datapath of the page tracker: input register, entry table, parallel key match.
// Depends on bprt_pkg.
module bprt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bprt_pkg::dp_cmd_t  cmd,
	output bprt_pkg::dp_stat_t stat,
	input  logic [1:0]         geo_scope,
	input  logic [9:0]         message_code,
	input  logic [3:0]         update_number,
	input  logic [15:0]        message_id,
	input  logic [3:0]         page_number,
	input  logic [3:0]         total_pages,
	output logic [2:0]         status,
	output logic [3:0]         pages_received,
	output logic [2:0]         slot
);
	import bprt_pkg::*;

	logic [KeyW-1:0] key_q;
	logic [3:0] upd_q, page_q, tot_q;

	logic [Entries-1:0] valid_q;
	logic [KeyW-1:0] ekey_q [Entries];
	logic [3:0] eupd_q [Entries];
	logic [3:0] etot_q [Entries];
	logic [15:0] emask_q [Entries];
	logic [3:0] etally_q [Entries];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= {geo_scope, message_code, message_id};
			upd_q <= update_number;
			page_q <= page_number;
			tot_q <= total_pages;
		end
	end

	logic [3:0] tot_eff;
	logic [Entries-1:0] hit;
	logic hit_any, free_any;
	logic [IdxW-1:0] hit_idx, free_idx;
	logic [15:0] bit_m;
	logic [4:0] tally_n;

	always_comb begin
		tot_eff = (tot_q == 4'd0) ? 4'd1 : tot_q;
		if (tot_eff > 4'(PageLimit)) tot_eff = 4'(PageLimit);
		bit_m = 16'd1 << page_q;
		hit_any = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = Entries - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && (ekey_q[i] == key_q);
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = IdxW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IdxW'(i);
			end
		end
		tally_n = {1'b0, etally_q[hit_idx]} + 5'd1;
	end

	assign stat.dummy_ok = 1'b1;

	typedef enum logic [2:0] {
		A_NONE, A_START_HIT, A_START_FREE, A_ADD, A_DONE
	} act_t;
	act_t act;
	status_t st_n;
	logic [3:0] pr_n;
	logic [IdxW-1:0] sl_n;

	always_comb begin
		act = A_NONE;
		st_n = ST_COMPLETE;
		pr_n = 4'd1;
		sl_n = '0;
		if (tot_eff <= 4'd1) begin
			act = A_NONE;
		end else if (hit_any) begin
			sl_n = hit_idx;
			if (upd_q > eupd_q[hit_idx]) begin
				act = A_START_HIT; st_n = ST_RECORDED; pr_n = 4'd1;
			end else if (upd_q < eupd_q[hit_idx]) begin
				st_n = ST_STALE; pr_n = 4'd0;
			end else if ((emask_q[hit_idx] & bit_m) != 16'd0) begin
				st_n = ST_DUPLICATE; pr_n = 4'd0;
			end else if (tally_n >= {1'b0, etot_q[hit_idx]}) begin
				act = A_DONE; st_n = ST_COMPLETE; pr_n = tally_n[3:0];
			end else begin
				act = A_ADD; st_n = ST_RECORDED; pr_n = tally_n[3:0];
			end
		end else if (free_any) begin
			act = A_START_FREE; st_n = ST_RECORDED; pr_n = 4'd1; sl_n = free_idx;
		end else begin
			st_n = ST_FULL; pr_n = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.update) begin
			if (act == A_START_HIT || act == A_START_FREE) valid_q[sl_n] <= 1'b1;
			else if (act == A_DONE) valid_q[sl_n] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (act == A_START_HIT || act == A_START_FREE) begin
				ekey_q[sl_n] <= key_q;
				eupd_q[sl_n] <= upd_q;
				etot_q[sl_n] <= tot_eff;
				emask_q[sl_n] <= bit_m;
				etally_q[sl_n] <= 4'd1;
			end else if (act == A_ADD || act == A_DONE) begin
				emask_q[sl_n] <= emask_q[sl_n] | bit_m;
				etally_q[sl_n] <= tally_n[3:0];
			end
		end
		if (cmd.load_out) begin
			status <= st_n;
			pages_received <= pr_n;
			slot <= 3'(sl_n);
		end
	end
endmodule

>>> rtl/core/broadcast_page_reassembly_tracker.sv
// Broadcast page reassembly tracker, top level.
// Flow: an accepted beat is registered at the input, its result is registered in the lookup state
// and held in the hold state; a new page is taken only in idle or as the held result leaves.
// Reset: arst_n clears all entry valid bits and the controller; other storage is unset.
// Depends on bprt_pkg, bprt_ctrl and bprt_dp.
module broadcast_page_reassembly_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  geo_scope,
	input  logic [9:0]  message_code,
	input  logic [3:0]  update_number,
	input  logic [15:0] message_id,
	input  logic [3:0]  page_number,
	input  logic [3:0]  total_pages,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  pages_received,
	output logic [2:0]  slot
);
	import bprt_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	bprt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
	);

	bprt_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .geo_scope, .message_code, .update_number,
		.message_id, .page_number, .total_pages, .status, .pages_received, .slot
	);
endmodule

>>> rtl/core/bprt_checker.sv
// Port-level checks for the page tracker, bound to the top level.
// Depends on bprt_pkg and broadcast_page_reassembly_tracker.
module bprt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [3:0] pages_received
);
	import bprt_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result changed while stalled");
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted beat gave no result");
	a_discard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUPLICATE || status == ST_STALE || status == ST_FULL)
		|-> pages_received == 4'd0)
		else $error("discarded page reports pages");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL)
		else $error("bad status code");
endmodule

bind broadcast_page_reassembly_tracker bprt_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status, .pages_received
);

>>> bench/broadcast_page_reassembly_tracker_test.sv
// Self-checking bench for the broadcast page reassembly tracker.
// A queue-fed driver and a monitor check every result beat against a reassembly-table predictor.
// Depends on bprt_pkg and the broadcast_page_reassembly_tracker RTL.
module broadcast_page_reassembly_tracker_test;
	import bprt_pkg::*;

	typedef struct packed {
		logic [1:0]  geo;
		logic [9:0]  code;
		logic [3:0]  upd;
		logic [15:0] id;
		logic [3:0]  page;
		logic [3:0]  total;
	} page_hdr_t;

	typedef struct packed {
		status_t    st;
		logic [3:0] pages;
		logic [2:0] slot;
	} page_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] geo_scope = '0;
	logic [9:0] message_code = '0;
	logic [3:0] update_number = '0;
	logic [15:0] message_id = '0;
	logic [3:0] page_number = '0;
	logic [3:0] total_pages = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [3:0] pages_received;
	logic [2:0] slot;

	broadcast_page_reassembly_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.geo_scope(geo_scope), .message_code(message_code),
		.update_number(update_number), .message_id(message_id),
		.page_number(page_number), .total_pages(total_pages),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pages_received(pages_received), .slot(slot)
	);

	// Predictor copy of the reassembly table.
	logic        tbl_valid [Entries];
	logic [27:0] tbl_key [Entries];
	logic [3:0]  tbl_upd [Entries];
	logic [3:0]  tbl_total [Entries];
	logic [15:0] tbl_mask [Entries];
	logic [3:0]  tbl_tally [Entries];

	page_hdr_t     pending_pages[$];
	page_verdict_t expected_verdicts[$];
	int  errors = 0;
	int  cycle_count = 0;
	bit  stim_done = 1'b0;
	bit  calm = 1'b0;
	bit  in_taken = 1'b0;
	int  hold_cycles = 0;
	int  tx_idle = 0;
	int  rx_idle = 0;

	function automatic page_verdict_t track_page(page_hdr_t h);
		page_verdict_t v;
		logic [27:0] key;
		logic [4:0] tally;
		logic [3:0] tot;
		int hit;
		int free_e;
		key = {h.geo, h.code, h.id};
		tot = (h.total == 0) ? 4'd1 : h.total;
		if (tot > PageLimit)
			tot = 4'(PageLimit);
		hit = -1;
		free_e = -1;
		if (tot <= 1) begin
			v = '{ST_COMPLETE, 4'd1, 3'd0};
			return v;
		end
		for (int e = Entries - 1; e >= 0; e--) begin
			if (tbl_valid[e] && tbl_key[e] == key)
				hit = e;
			if (!tbl_valid[e])
				free_e = e;
		end
		if (hit < 0 && free_e < 0) begin
			v = '{ST_FULL, 4'd0, 3'd0};
		end else if (hit < 0 || h.upd > tbl_upd[hit]) begin
			if (hit < 0)
				hit = free_e;
			tbl_valid[hit] = 1'b1;
			tbl_key[hit] = key;
			tbl_upd[hit] = h.upd;
			tbl_total[hit] = tot;
			tbl_mask[hit] = 16'd1 << h.page;
			tbl_tally[hit] = 4'd1;
			v = '{ST_RECORDED, 4'd1, 3'(hit)};
		end else if (h.upd < tbl_upd[hit]) begin
			v = '{ST_STALE, 4'd0, 3'(hit)};
		end else if (tbl_mask[hit][h.page]) begin
			v = '{ST_DUPLICATE, 4'd0, 3'(hit)};
		end else begin
			tally = tbl_tally[hit] + 5'd1;
			tbl_mask[hit][h.page] = 1'b1;
			tbl_tally[hit] = tally[3:0];
			if (tally >= tbl_total[hit]) begin
				tbl_valid[hit] = 1'b0;
				v = '{ST_COMPLETE, tally[3:0], 3'(hit)};
			end else begin
				v = '{ST_RECORDED, tally[3:0], 3'(hit)};
			end
		end
		return v;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	// Acceptance is seen at the rising edge, where the handshake takes place.
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall && arst_n;
	end

	// Driver: offers the head of the queue, with random gaps.
	always @(negedge clk) begin
		if (in_taken)
			expected_verdicts = {expected_verdicts, track_page(pending_pages.pop_front())};
		if (pending_pages.size() < 100)
			calm <= 1'b1;
		if (in_valid && !in_taken) begin
			// The offered beat waits unchanged until it is taken.
		end else if (tx_idle > 0) begin
			tx_idle <= tx_idle - 1;
			in_valid <= 1'b0;
		end else if (pending_pages.size() > 0 && arst_n) begin
			in_valid <= 1'b1;
			geo_scope <= pending_pages[0].geo;
			message_code <= pending_pages[0].code;
			update_number <= pending_pages[0].upd;
			message_id <= pending_pages[0].id;
			page_number <= pending_pages[0].page;
			total_pages <= pending_pages[0].total;
			if (!calm && $urandom_range(0, 9) == 0)
				tx_idle <= $urandom_range(1, 8);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver stalls: a long hold once, bursts otherwise.
	always @(negedge clk) begin
		if (cycle_count == 300) begin
			hold_cycles <= 60;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (rx_idle > 0) begin
			rx_idle <= rx_idle - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 9) == 0)
				rx_idle <= $urandom_range(1, 8);
		end
	end

	// Monitor.
	always @(posedge clk) begin
		page_verdict_t exp_v;
		if (arst_n)
			cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result status=%0d pages=%0d slot=%0d",
					$time, status, pages_received, slot);
				errors <= errors + 1;
			end else begin
				exp_v = expected_verdicts.pop_front();
				if (exp_v.st !== status || exp_v.pages !== pages_received
						|| exp_v.slot !== slot) begin
					$display("%0t: expected st/pages/slot %0d/%0d/%0d, got %0d/%0d/%0d",
						$time, exp_v.st, exp_v.pages, exp_v.slot,
						status, pages_received, slot);
					errors <= errors + 1;
				end
			end
		end
	end

	task automatic add_page(logic [1:0] g, logic [9:0] c, logic [3:0] u, logic [15:0] i,
			logic [3:0] p, logic [3:0] t);
		page_hdr_t h;
		h = '{g, c, u, i, p, t};
		pending_pages = {pending_pages, h};
	endtask

	// Message keys are drawn from a small pool so that pages meet their entries.
	logic [1:0]  pool_geo [12];
	logic [9:0]  pool_code [12];
	logic [15:0] pool_id [12];

	initial begin
		int k;
		int n;
		int r;
		for (int e = 0; e < Entries; e++)
			tbl_valid[e] = 1'b0;
		// Directed part.
		add_page(2'd3, 10'h3ff, 4'd15, 16'hffff, 4'd15, 4'd0);
		add_page(2'd0, 10'd0, 4'd0, 16'd0, 4'd0, 4'd1);
		add_page(2'd1, 10'd5, 4'd2, 16'd100, 4'd0, 4'd3);
		add_page(2'd1, 10'd5, 4'd2, 16'd100, 4'd0, 4'd3);
		add_page(2'd1, 10'd5, 4'd1, 16'd100, 4'd1, 4'd3);
		add_page(2'd1, 10'd5, 4'd2, 16'd100, 4'd9, 4'd5);
		add_page(2'd1, 10'd5, 4'd2, 16'd100, 4'd2, 4'd3);
		add_page(2'd2, 10'd7, 4'd1, 16'd9, 4'd1, 4'd2);
		add_page(2'd2, 10'd7, 4'd4, 16'd9, 4'd1, 4'd2);
		add_page(2'd2, 10'd7, 4'd4, 16'd9, 4'd0, 4'd2);
		add_page(2'd2, 10'd7, 4'd0, 16'd9, 4'd0, 4'd1);
		for (int j = 0; j < 9; j++)
			add_page(2'(j), 10'(j * 100), 4'd0, 16'(j * 7000), 4'd1, 4'd15);
		add_page(2'd0, 10'd0, 4'd0, 16'd0, 4'd2, 4'd15);
		for (int j = 0; j < 8; j++)
			add_page(2'(j), 10'(j * 100), 4'd1, 16'(j * 7000), 4'd0, 4'd2);
		add_page(2'd0, 10'd0, 4'd1, 16'd0, 4'd14, 4'd2);
		for (int j = 0; j < 12; j++) begin
			pool_geo[j] = 2'($urandom);
			pool_code[j] = 10'($urandom);
			pool_id[j] = 16'($urandom);
		end
		// Random part: mostly pages of pooled messages, some noise.
		n = 0;
		while (n < 950) begin
			r = int'($urandom_range(0, 9));
			k = int'($urandom_range(0, 11));
			if (r == 0)
				add_page(2'($urandom), 10'($urandom), 4'($urandom), 16'($urandom),
					4'($urandom), 4'($urandom));
			else if (r == 1)
				add_page(pool_geo[k], pool_code[k], 4'($urandom), pool_id[k],
					4'($urandom), 4'($urandom_range(0, 1)));
			else
				add_page(pool_geo[k], pool_code[k], 4'($urandom_range(0, 2)), pool_id[k],
					4'($urandom_range(0, 5)), 4'($urandom_range(2, 5)));
			if ($urandom_range(0, 199) == 0)
				pool_id[k] = 16'($urandom);
			n++;
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && pending_pages.size() == 0 && !in_valid
			&& expected_verdicts.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_verdicts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		wait (cycle_count == 200000);
		$display("FAILED: results differ");
		$finish;
	end
endmodule
